// File: rtl/core/tdf_pkg.sv
// tdf_pkg: shared types and constants for the trial division factorizer
// no dependencies; imported by every module under rtl/core
`timescale 1ns / 1ps
package tdf_pkg;
   localparam int ValueWidth  = 16;
   localparam int PrimeCount  = 54;
   localparam int PidxWidth   = 6;
   localparam int MaxFactors  = 6;
   localparam int CountWidth  = 3;
   localparam int ExpWidth    = 4;
   localparam int ExpMax      = 15;
   localparam int QueueDepth  = 2;

   // queued job from the front part to the divider
   typedef struct packed {
      logic [ValueWidth-1:0] value;
      logic                  trivial;
   } job_type;

   // one recorded prime and exponent pair
   typedef struct packed {
      logic [ValueWidth-1:0] prime;
      logic [ExpWidth-1:0]   exponent;
   } factor_type;

   // primes 2..251 that stand in for the sieve
   function automatic logic [7:0] prime_at(input logic [PidxWidth-1:0] idx);
      logic [7:0] p;
      unique case (idx)
         6'd0: p = 8'd2;     6'd1: p = 8'd3;     6'd2: p = 8'd5;     6'd3: p = 8'd7;
         6'd4: p = 8'd11;    6'd5: p = 8'd13;    6'd6: p = 8'd17;    6'd7: p = 8'd19;
         6'd8: p = 8'd23;    6'd9: p = 8'd29;    6'd10: p = 8'd31;   6'd11: p = 8'd37;
         6'd12: p = 8'd41;   6'd13: p = 8'd43;   6'd14: p = 8'd47;   6'd15: p = 8'd53;
         6'd16: p = 8'd59;   6'd17: p = 8'd61;   6'd18: p = 8'd67;   6'd19: p = 8'd71;
         6'd20: p = 8'd73;   6'd21: p = 8'd79;   6'd22: p = 8'd83;   6'd23: p = 8'd89;
         6'd24: p = 8'd97;   6'd25: p = 8'd101;  6'd26: p = 8'd103;  6'd27: p = 8'd107;
         6'd28: p = 8'd109;  6'd29: p = 8'd113;  6'd30: p = 8'd127;  6'd31: p = 8'd131;
         6'd32: p = 8'd137;  6'd33: p = 8'd139;  6'd34: p = 8'd149;  6'd35: p = 8'd151;
         6'd36: p = 8'd157;  6'd37: p = 8'd163;  6'd38: p = 8'd167;  6'd39: p = 8'd173;
         6'd40: p = 8'd179;  6'd41: p = 8'd181;  6'd42: p = 8'd191;  6'd43: p = 8'd193;
         6'd44: p = 8'd197;  6'd45: p = 8'd199;  6'd46: p = 8'd211;  6'd47: p = 8'd223;
         6'd48: p = 8'd227;  6'd49: p = 8'd229;  6'd50: p = 8'd233;  6'd51: p = 8'd239;
         6'd52: p = 8'd241;  6'd53: p = 8'd251;
         default: p = 8'd0;
      endcase
      return p;
   endfunction
endpackage

// File: rtl/core/trial_division_factorizer_top.sv
// trial_division_factorizer_top: prime factorization by trial division
// depends on tdf_pkg, tdf_front, tdf_back
//
//   channel  ports                                                     dir
//   req      req_valid req_stall req_value                             in
//   rsp      rsp_valid rsp_stall rsp_prime_factor rsp_exponent
//            rsp_no_factors rsp_last                                   out
//
// each trial prime is tried by repeated division, one quotient bit a cycle
// in the back part's shift-subtract divider; the result pairs are then
// emitted one per beat
// a two-entry queue lets the front take new values while the back works
// synchronous active-high reset clears control; no clearing pass
`timescale 1ns / 1ps
module trial_division_factorizer_top import tdf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [ValueWidth-1:0] req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [ValueWidth-1:0] rsp_prime_factor,
   output logic [ExpWidth-1:0]   rsp_exponent,
   output logic                  rsp_no_factors,
   output logic                  rsp_last
);
   logic    job_valid, job_take;
   job_type job_data;

   tdf_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_value,
      .job_valid, .job_take, .job_data
   );

   tdf_back u_back (
      .clock, .reset, .job_valid, .job_take, .job_data,
      .rsp_valid, .rsp_stall, .rsp_prime_factor, .rsp_exponent,
      .rsp_no_factors, .rsp_last
   );
endmodule

// File: rtl/core/tdf_front.sv
// tdf_front: accepts values, flags zero and one, and queues jobs
// depends on tdf_pkg
`timescale 1ns / 1ps
module tdf_front import tdf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [ValueWidth-1:0] req_value,
   output logic                  job_valid,
   input  logic                  job_take,
   output job_type               job_data
);
   job_type    queue_ff [QueueDepth];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push, pop;

   // two-entry queue between front and back
   assign req_stall = (fill_ff == 2'(QueueDepth));
   assign push      = req_valid && !req_stall;
   assign job_valid = (fill_ff != 2'd0);
   assign pop       = job_valid && job_take;
   assign job_data  = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // classify at entry
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff].value   <= req_value;
         queue_ff[wr_ptr_ff].trivial <= (req_value <= ValueWidth'(1));
      end
   end

`ifndef NO_ASSERTIONS
   a_fill_max: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= 2'(QueueDepth)) else $error("queue overfilled");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == 2'(QueueDepth) && !pop) |=> fill_ff == 2'(QueueDepth))
      else $error("full queue lost an entry");
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> fill_ff == $past(fill_ff) + 2'd1)
      else $error("push not counted");
`endif
endmodule

// File: rtl/core/tdf_back.sv
// tdf_back: trial division sequencer, factor buffer and result emitter
// depends on tdf_pkg
`timescale 1ns / 1ps
module tdf_back import tdf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  job_valid,
   output logic                  job_take,
   input  job_type               job_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [ValueWidth-1:0] rsp_prime_factor,
   output logic [ExpWidth-1:0]   rsp_exponent,
   output logic                  rsp_no_factors,
   output logic                  rsp_last
);
   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_CHECK = 6'b000010,
      S_DIV   = 6'b000100,
      S_STEP  = 6'b001000,
      S_EMIT  = 6'b010000,
      S_TRIV  = 6'b100000
   } state_type;

   state_type             state_ff, state_in;
   logic [ValueWidth-1:0] n_ff, n_in;
   logic [PidxWidth-1:0]  pidx_ff, pidx_in;
   logic [ExpWidth-1:0]   exp_ff, exp_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [ValueWidth-1:0] quot_ff, quot_in;
   logic [ValueWidth-1:0] rem_ff, rem_in;
   logic [4:0]            bit_ff, bit_in;
   factor_type            buf_ff [MaxFactors];
   logic                  rec_en;
   factor_type            rec_data;
   logic                  out_full_ff;
   logic                  out_load;
   logic [7:0]            p;
   logic [15:0]           psq;
   logic [ValueWidth:0]   trial;
   logic                  done_emit;

   assign p     = prime_at(pidx_ff);
   assign psq   = p * p;
   assign trial = {rem_ff, n_ff[bit_ff[3:0]]} - {{(ValueWidth-7){1'b0}}, p};

   // output register frees when taken
   assign out_load  = !out_full_ff || !rsp_stall;
   assign rsp_valid = out_full_ff;
   assign job_take  = (state_ff == S_IDLE);
   assign done_emit = (count_ff == CountWidth'(1));

   always_comb begin
      state_in = state_ff;
      n_in     = n_ff;
      pidx_in  = pidx_ff;
      exp_in   = exp_ff;
      count_in = count_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      bit_in   = bit_ff;
      rec_en   = 1'b0;
      rec_data = '{prime: {{(ValueWidth-8){1'b0}}, p}, exponent: exp_ff};
      unique case (state_ff)
         S_IDLE: begin
            if (job_valid) begin
               n_in     = job_data.value;
               pidx_in  = '0;
               exp_in   = '0;
               count_in = '0;
               state_in = job_data.trivial ? S_TRIV : S_CHECK;
            end
         end
         // stop on square above remainder or table end
         S_CHECK: begin
            if ({16'd0, psq} > 32'(n_ff) || pidx_ff == PidxWidth'(PrimeCount)) begin
               if (n_ff > ValueWidth'(1) && count_ff < CountWidth'(MaxFactors)) begin
                  rec_en   = 1'b1;
                  rec_data = '{prime: n_ff, exponent: ExpWidth'(1)};
                  count_in = count_ff + CountWidth'(1);
               end
               state_in = S_EMIT;
            end else begin
               quot_in  = '0;
               rem_in   = '0;
               bit_in   = 5'(ValueWidth - 1);
               state_in = S_DIV;
            end
         end
         // restoring division one bit a cycle
         S_DIV: begin
            if (!trial[ValueWidth]) begin
               rem_in = trial[ValueWidth-1:0];
               quot_in = {quot_ff[ValueWidth-2:0], 1'b1};
            end else begin
               rem_in = {rem_ff[ValueWidth-2:0], n_ff[bit_ff[3:0]]};
               quot_in = {quot_ff[ValueWidth-2:0], 1'b0};
            end
            if (bit_ff == 5'd0) state_in = S_STEP;
            else bit_in = bit_ff - 5'd1;
         end
         S_STEP: begin
            if (rem_ff == '0) begin
               n_in     = quot_ff;
               exp_in   = (exp_ff == ExpWidth'(ExpMax)) ? exp_ff : exp_ff + ExpWidth'(1);
               quot_in  = '0;
               rem_in   = '0;
               bit_in   = 5'(ValueWidth - 1);
               state_in = S_DIV;
            end else begin
               if (exp_ff != '0 && count_ff < CountWidth'(MaxFactors)) begin
                  rec_en   = 1'b1;
                  count_in = count_ff + CountWidth'(1);
               end
               exp_in   = '0;
               pidx_in  = pidx_ff + PidxWidth'(1);
               state_in = S_CHECK;
            end
         end
         S_EMIT: begin
            if (out_load) begin
               count_in = count_ff - CountWidth'(1);
               if (done_emit) state_in = S_IDLE;
            end
         end
         S_TRIV: begin
            if (out_load) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         count_ff    <= '0;
         out_full_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (out_load)
            out_full_ff <= (state_ff == S_EMIT) || (state_ff == S_TRIV);
      end
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      pidx_ff <= pidx_in;
      exp_ff  <= exp_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      bit_ff  <= bit_in;
      if (rec_en) buf_ff[count_ff] <= rec_data;
   end

   // result register, newest pair first
   always_ff @(posedge clock) begin
      if (out_load) begin
         if (state_ff == S_TRIV) begin
            rsp_prime_factor <= '0;
            rsp_exponent     <= '0;
            rsp_no_factors   <= 1'b1;
            rsp_last         <= 1'b1;
         end else begin
            rsp_prime_factor <= buf_ff[count_ff - CountWidth'(1)].prime;
            rsp_exponent     <= buf_ff[count_ff - CountWidth'(1)].exponent;
            rsp_no_factors   <= 1'b0;
            rsp_last         <= done_emit;
         end
      end
   end

`ifndef NO_ASSERTIONS
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(MaxFactors)) else $error("factor count overflow");
   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT |-> count_ff != '0) else $error("emit with empty buffer");
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      (job_take && job_valid) |=> state_ff != S_IDLE) else $error("job dropped");
`endif
endmodule
